// ===== rtl/core/acfd_pkg.sv =====
`timescale 1ns / 1ps
// acfd_pkg: shared types, codes and constant tables of the remote frame decoder
// no dependencies

package acfd_pkg;

   typedef logic [7:0] byte_type;

   localparam int FRAME_LEN = 13;
   localparam int LAST_IDX  = FRAME_LEN - 1;
   localparam int POS_W     = 4;
   localparam logic [POS_W-1:0] LAST_POS = POS_W'(LAST_IDX);
   localparam logic [POS_W-1:0] FIRST_POS = '0;

   localparam int QUEUE_DEPTH_DEF = 2;

   localparam byte_type SIG_BYTE     = 8'hC3;
   localparam byte_type SENSOR_OFS   = 8'h4A;
   localparam byte_type CMD_SPECIAL  = 8'h0D;
   localparam byte_type SENSOR_LIMIT = 8'd50;

   localparam logic [5:0] TGT_BIAS = 6'd8;
   localparam logic [5:0] TGT_MIN  = 6'd16;
   localparam logic [5:0] TGT_MAX  = 6'd32;

   // the two fixed timer-off frames
   localparam byte_type TIMER30_TAB [FRAME_LEN] = '{
      8'hC3, 8'h97, 8'h00, 8'h00, 8'h40, 8'h1E, 8'h48,
      8'h5E, 8'h00, 8'h60, 8'h00, 8'h0D, 8'hCB};
   localparam byte_type TIMER60_TAB [FRAME_LEN] = '{
      8'hC3, 8'h97, 8'h00, 8'h00, 8'h41, 8'h00, 8'h48,
      8'h5E, 8'h00, 8'h60, 8'h00, 8'h0D, 8'hAE};

   // result status
   localparam logic [2:0] ST_OK       = 3'd0;
   localparam logic [2:0] ST_CHECKSUM = 3'd1;
   localparam logic [2:0] ST_MODE     = 3'd2;
   localparam logic [2:0] ST_FAN      = 3'd3;
   localparam logic [2:0] ST_TARGET   = 3'd4;
   localparam logic [2:0] ST_SENSOR   = 3'd5;

   // frame kind
   localparam logic [1:0] KIND_PLAIN   = 2'd0;
   localparam logic [1:0] KIND_SPECIAL = 2'd1;
   localparam logic [1:0] KIND_TIMER30 = 2'd2;
   localparam logic [1:0] KIND_TIMER60 = 2'd3;

   // decoded mode and the raw codes in byte 6 bits 7:5
   localparam logic [2:0] OPM_AUTO    = 3'd0;
   localparam logic [2:0] OPM_COOL    = 3'd1;
   localparam logic [2:0] OPM_DRY     = 3'd2;
   localparam logic [2:0] OPM_HEAT    = 3'd3;
   localparam logic [2:0] OPM_FANONLY = 3'd4;
   localparam logic [2:0] MRAW_AUTO = 3'b000;
   localparam logic [2:0] MRAW_COOL = 3'b001;
   localparam logic [2:0] MRAW_DRY  = 3'b010;
   localparam logic [2:0] MRAW_HEAT = 3'b100;
   localparam logic [2:0] MRAW_FAN  = 3'b110;

   // decoded fan and the raw codes in byte 4 bits 7:5
   localparam logic [1:0] FAN_HIGH = 2'd0;
   localparam logic [1:0] FAN_MED  = 2'd1;
   localparam logic [1:0] FAN_LOW  = 2'd2;
   localparam logic [1:0] FAN_AUTO = 2'd3;
   localparam logic [2:0] FRAW_HIGH = 3'b001;
   localparam logic [2:0] FRAW_MED  = 3'b010;
   localparam logic [2:0] FRAW_LOW  = 3'b011;
   localparam logic [2:0] FRAW_AUTO = 3'b101;

   // classified frame handed from front to back
   typedef struct packed {
      logic     chk_ok;
      logic     timer30;
      logic     timer60;
      byte_type b1;
      byte_type b2;
      byte_type b4;
      byte_type b5;
      byte_type b6;
      byte_type b7;
      byte_type b9;
      byte_type b11;
   } frame_rec_type;

   localparam int REC_W = $bits(frame_rec_type);

   typedef struct packed {
      logic [2:0] status;
      logic [1:0] frame_kind;
      logic [2:0] op_mode;
      logic [1:0] fan_speed;
      logic [5:0] target_temp;
      logic [5:0] sensor_temp;
      byte_type   flag_bits;
      byte_type   command_code;
   } result_type;

   typedef struct packed {
      logic push;
      logic pop;
   } q_ctl_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_stat_type;

endpackage

// ===== rtl/core/acfd_if.sv =====
`timescale 1ns / 1ps
// acfd_req_if / acfd_rsp_if: valid/ready channels of the remote frame decoder
// no dependencies

interface acfd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] frame_byte;
   logic       frame_start;

   modport source (output valid, output frame_byte, output frame_start, input ready);
   modport sink   (input valid, input frame_byte, input frame_start, output ready);
endinterface

interface acfd_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] status;
   logic [1:0] frame_kind;
   logic [2:0] op_mode;
   logic [1:0] fan_speed;
   logic [5:0] target_temp;
   logic [5:0] sensor_temp;
   logic [7:0] flag_bits;
   logic [7:0] command_code;

   modport source (output valid, output status, output frame_kind, output op_mode,
                   output fan_speed, output target_temp, output sensor_temp,
                   output flag_bits, output command_code, input ready);
   modport sink   (input valid, input status, input frame_kind, input op_mode,
                   input fan_speed, input target_temp, input sensor_temp,
                   input flag_bits, input command_code, output ready);
endinterface

// ===== rtl/core/acfd_front.sv =====
`timescale 1ns / 1ps
// acfd_front: takes frame bytes, keeps position, checksum and stored bytes,
// and classifies a finished frame into a queue record; uses acfd_pkg, acfd_req_if

module acfd_front (
   input  logic                   clock,
   input  logic                   reset,
   acfd_req_if.sink               req_chan,
   input  acfd_pkg::q_stat_type   q_stat,
   output logic                   push,
   output acfd_pkg::frame_rec_type rec
);
   import acfd_pkg::*;

   logic [POS_W-1:0] pos_ff, pos_in, cur_pos;
   byte_type         sum_ff, sum_in;
   byte_type         byte_ff [LAST_IDX];
   byte_type         byte_in [LAST_IDX];
   logic             accept, last;
   logic             t30, t60;
   byte_type         b;

   assign req_chan.ready = !q_stat.full;
   assign accept  = req_chan.valid && req_chan.ready;
   assign b       = req_chan.frame_byte;
   assign cur_pos = req_chan.frame_start ? FIRST_POS : pos_ff;
   assign last    = (cur_pos == LAST_POS);
   assign push    = accept && last;

   always_comb begin
      pos_in  = pos_ff;
      sum_in  = sum_ff;
      byte_in = byte_ff;
      if (accept) begin
         if (last) begin
            pos_in = FIRST_POS;
            sum_in = '0;
         end else begin
            pos_in           = cur_pos + POS_W'(1);
            sum_in           = (cur_pos == FIRST_POS) ? b : sum_ff + b;
            byte_in[cur_pos] = b;
         end
      end
   end

   // timer frames match every stored byte plus the closing byte
   always_comb begin
      t30 = (b == TIMER30_TAB[LAST_IDX]);
      t60 = (b == TIMER60_TAB[LAST_IDX]);
      for (int i = 0; i < LAST_IDX; i++) begin
         t30 = t30 && (byte_ff[i] == TIMER30_TAB[i]);
         t60 = t60 && (byte_ff[i] == TIMER60_TAB[i]);
      end
   end

   always_comb begin
      rec.chk_ok  = (byte_ff[0] == SIG_BYTE) && (b == sum_ff);
      rec.timer30 = t30;
      rec.timer60 = t60;
      rec.b1      = byte_ff[1];
      rec.b2      = byte_ff[2];
      rec.b4      = byte_ff[4];
      rec.b5      = byte_ff[5];
      rec.b6      = byte_ff[6];
      rec.b7      = byte_ff[7];
      rec.b9      = byte_ff[9];
      rec.b11     = byte_ff[11];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= FIRST_POS;
         sum_ff <= '0;
      end else begin
         pos_ff <= pos_in;
         sum_ff <= sum_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
   end

endmodule

// ===== rtl/core/acfd_fifo.sv =====
`timescale 1ns / 1ps
// acfd_fifo: small register queue between the front and back parts
// uses acfd_pkg for the control and status structs

module acfd_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic                 clock,
   input  logic                 reset,
   input  acfd_pkg::q_ctl_type  ctl,
   input  logic [WIDTH-1:0]     wr_data,
   output acfd_pkg::q_stat_type stat,
   output logic [WIDTH-1:0]     rd_data
);
   import acfd_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   assign stat.full  = (cnt_ff == CNT_FULL);
   assign stat.empty = (cnt_ff == '0);
   assign rd_data    = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (ctl.push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (ctl.pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (ctl.push && !ctl.pop) begin
         cnt_in = cnt_ff + CNT_W'(1);
      end else if (!ctl.push && ctl.pop) begin
         cnt_in = cnt_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.push) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

// ===== rtl/core/acfd_back.sv =====
`timescale 1ns / 1ps
// acfd_back: decodes a classified frame into the result fields and holds them
// in the output register; uses acfd_pkg, acfd_rsp_if

module acfd_back (
   input  logic                    clock,
   input  logic                    reset,
   input  acfd_pkg::frame_rec_type rec,
   input  acfd_pkg::q_stat_type    q_stat,
   output logic                    pop,
   acfd_rsp_if.source              rsp_chan
);
   import acfd_pkg::*;

   logic       rsp_valid_ff, rsp_valid_in;
   result_type res_ff, res_in, dec;
   logic       mode_ok, fan_ok, tgt_bad, sen_bad, ifeel, need_tgt;
   logic [2:0] mode_val;
   logic [1:0] fan_val;
   logic [5:0] tgt_sum;
   byte_type   sen_diff;
   byte_type   flags;

   assign pop = !q_stat.empty && (!rsp_valid_ff || rsp_chan.ready);

   always_comb begin
      mode_ok  = 1'b1;
      mode_val = OPM_AUTO;
      case (rec.b6[7:5])
         MRAW_AUTO: mode_val = OPM_AUTO;
         MRAW_COOL: mode_val = OPM_COOL;
         MRAW_DRY:  mode_val = OPM_DRY;
         MRAW_HEAT: mode_val = OPM_HEAT;
         MRAW_FAN:  mode_val = OPM_FANONLY;
         default:   mode_ok  = 1'b0;
      endcase
      fan_ok  = 1'b1;
      fan_val = FAN_HIGH;
      case (rec.b4[7:5])
         FRAW_HIGH: fan_val = FAN_HIGH;
         FRAW_MED:  fan_val = FAN_MED;
         FRAW_LOW:  fan_val = FAN_LOW;
         FRAW_AUTO: fan_val = FAN_AUTO;
         default:   fan_ok  = 1'b0;
      endcase
   end

   assign need_tgt = mode_val inside {OPM_COOL, OPM_DRY, OPM_HEAT};
   assign tgt_sum  = 6'(rec.b1[7:3]) + TGT_BIAS;
   assign tgt_bad  = need_tgt && ((tgt_sum < TGT_MIN) || (tgt_sum > TGT_MAX));
   assign ifeel    = rec.b6[3];
   assign sen_diff = rec.b7 - SENSOR_OFS;
   assign sen_bad  = ifeel && ((rec.b7 < SENSOR_OFS) || (sen_diff > SENSOR_LIMIT));

   assign flags = {rec.b2[7:5] == 3'b000, rec.b1[2:0] == 3'b000, ifeel, rec.b6[2],
                   rec.b5[6], rec.b9[1], rec.b9[2], rec.b9[5]};

   // checks in priority order, first failure wins with all other fields zero
   always_comb begin
      dec = '0;
      if (!rec.chk_ok) begin
         dec.status = ST_CHECKSUM;
      end else if (rec.timer30) begin
         dec.frame_kind = KIND_TIMER30;
      end else if (rec.timer60) begin
         dec.frame_kind = KIND_TIMER60;
      end else if (!mode_ok) begin
         dec.status = ST_MODE;
      end else if (!fan_ok) begin
         dec.status = ST_FAN;
      end else if (tgt_bad) begin
         dec.status = ST_TARGET;
      end else if (sen_bad) begin
         dec.status = ST_SENSOR;
      end else begin
         dec.status       = ST_OK;
         dec.frame_kind   = (rec.b11 == CMD_SPECIAL) ? KIND_SPECIAL : KIND_PLAIN;
         dec.op_mode      = mode_val;
         dec.fan_speed    = fan_val;
         dec.target_temp  = need_tgt ? tgt_sum : '0;
         dec.sensor_temp  = ifeel ? sen_diff[5:0] : '0;
         dec.flag_bits    = flags;
         dec.command_code = rec.b11;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      res_in       = res_ff;
      if (pop) begin
         rsp_valid_in = 1'b1;
         res_in       = dec;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      res_ff <= res_in;
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.status       = res_ff.status;
   assign rsp_chan.frame_kind   = res_ff.frame_kind;
   assign rsp_chan.op_mode      = res_ff.op_mode;
   assign rsp_chan.fan_speed    = res_ff.fan_speed;
   assign rsp_chan.target_temp  = res_ff.target_temp;
   assign rsp_chan.sensor_temp  = res_ff.sensor_temp;
   assign rsp_chan.flag_bits    = res_ff.flag_bits;
   assign rsp_chan.command_code = res_ff.command_code;

endmodule

// ===== rtl/core/ac_ir_frame_decoder_core.sv =====
`timescale 1ns / 1ps
// ac_ir_frame_decoder_core: top level of the 13-byte remote frame decoder
// uses acfd_pkg, acfd_if, acfd_front, acfd_fifo, acfd_back

// The decoder takes one frame byte per cycle on req_chan; frame_start set on a
// byte makes it byte 0 of a new frame and drops any partial frame. After the
// 13th byte one result appears on rsp_chan: the front part stores bytes and
// sums the checksum, the edge that accepts the last byte writes the finished
// frame into a small queue (QUEUE_DEPTH records), and once the output register
// is free the back part decodes it into that register. Input is accepted every
// cycle unless the queue is full, which only happens when results are not
// being taken. There are no configuration registers; the first failing check
// sets status and zeroes all other fields.

module ac_ir_frame_decoder_core #(
   parameter int QUEUE_DEPTH = acfd_pkg::QUEUE_DEPTH_DEF
) (
   input  logic       clock,
   input  logic       reset,
   acfd_req_if.sink   req_chan,
   acfd_rsp_if.source rsp_chan
);
   import acfd_pkg::*;

   q_ctl_type     q_ctl;
   q_stat_type    q_stat;
   frame_rec_type rec_wr, rec_rd;
   logic          push, pop;
   logic [REC_W-1:0] rd_bits;

   assign q_ctl.push = push;
   assign q_ctl.pop  = pop;
   assign rec_rd     = frame_rec_type'(rd_bits);

   acfd_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .q_stat   (q_stat),
      .push     (push),
      .rec      (rec_wr)
   );

   acfd_fifo #(
      .WIDTH (REC_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock   (clock),
      .reset   (reset),
      .ctl     (q_ctl),
      .wr_data (rec_wr),
      .stat    (q_stat),
      .rd_data (rd_bits)
   );

   acfd_back u_back (
      .clock    (clock),
      .reset    (reset),
      .rec      (rec_rd),
      .q_stat   (q_stat),
      .pop      (pop),
      .rsp_chan (rsp_chan)
   );

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      q_ctl.push |-> !q_stat.full)
      else $error("queue written while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      q_ctl.pop |-> !q_stat.empty)
      else $error("queue read while empty");

   a_pop_loads_output: assert property (@(posedge clock) disable iff (reset)
      q_ctl.pop |=> rsp_chan.valid)
      else $error("decoded frame did not reach the output register");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && (rsp_chan.status != ST_OK)) |->
      (rsp_chan.frame_kind == KIND_PLAIN && rsp_chan.op_mode == '0 &&
       rsp_chan.fan_speed == '0 && rsp_chan.flag_bits == '0 &&
       rsp_chan.command_code == '0))
      else $error("failed frame carries nonzero fields");

endmodule
